FILE: hw/rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Beat payload types, function codes and fixed widths for the rc4 engine.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int KEY_LEN_W = 9;
  localparam int PERM_DEPTH = 256;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_CRYPT = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] key_index;
    logic [7:0] data_in;
  } in_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic [31:0] age_count;
  } out_t;

endpackage

FILE: hw/rtl/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/rc4_engine.sv
// ----------------------------------------------------------------------------
// rc4_engine
// Sequencer over the permutation and key memories: key load, key
// scheduling and one keystream step per encrypt beat.
// ----------------------------------------------------------------------------
module rc4_engine #(
  parameter int KEY_MAX = 256,
  parameter int KW      = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rc4_pkg::in_t                    in_data,
  input  logic [rc4_pkg::KEY_LEN_W-1:0]   period,
  output logic                            res_valid,
  input  logic                            res_ready,
  output rc4_pkg::out_t                   res
);

  import rc4_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INIT = 4'd1;
  localparam logic [3:0] ST_K_ACC = 4'd2;
  localparam logic [3:0] ST_K_WN = 4'd3;
  localparam logic [3:0] ST_K_WA = 4'd4;
  localparam logic [3:0] ST_E_RJ = 4'd5;
  localparam logic [3:0] ST_E_WI = 4'd6;
  localparam logic [3:0] ST_E_WJ = 4'd7;
  localparam logic [3:0] ST_E_KS = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [7:0]    n_r, n_nxt;
  logic [7:0]    acc_r, acc_nxt;
  logic [KW-1:0] kidx_r, kidx_nxt;
  logic [7:0]    i_r, i_nxt;
  logic [7:0]    j_r, j_nxt;
  logic [7:0]    sn_r, sn_nxt;
  logic [7:0]    sj_r, sj_nxt;
  logic [7:0]    data_r, data_nxt;
  logic          hz_r, hz_nxt;
  logic [31:0]   count_r, count_nxt;
  logic [31:0]   cnt_save_r, cnt_save_nxt;

  logic          p_we, p_re;
  logic [7:0]    p_waddr, p_wdata, p_raddr, p_rdata;
  logic          k_we, k_re;
  logic [KW-1:0] k_raddr;
  logic [7:0]    k_rdata;

  logic [7:0]    fwd;
  logic [7:0]    acc_sum;
  logic [7:0]    j_sum;
  logic [7:0]    ks_addr;
  logic [KW-1:0] kidx_adv;
  logic          key_ok;

  // a read issued alongside a write to the same entry sees the old byte
  assign fwd      = hz_r ? sn_r : p_rdata;
  assign acc_sum  = acc_r + k_rdata + fwd;
  assign j_sum    = j_r + p_rdata;
  assign ks_addr  = sn_r + sj_r;
  assign kidx_adv = ((KEY_LEN_W'(kidx_r) + KEY_LEN_W'(1)) == period) ? '0
                                                                      : kidx_r + KW'(1);
  assign key_ok   = {1'b0, in_data.key_index} < KEY_LEN_W'(KEY_MAX);
  assign in_ready = (state_r == ST_IDLE);

  rc4_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(.WIDTH(8), .DEPTH(KEY_MAX)) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (in_data.key_index[KW-1:0]),
    .wdata (in_data.data_in),
    .re    (k_re),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    n_nxt        = n_r;
    acc_nxt      = acc_r;
    kidx_nxt     = kidx_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    sn_nxt       = sn_r;
    sj_nxt       = sj_r;
    data_nxt     = data_r;
    hz_nxt       = hz_r;
    count_nxt    = count_r;
    cnt_save_nxt = cnt_save_r;
    p_we         = 1'b0;
    p_waddr      = n_r;
    p_wdata      = n_r;
    p_re         = 1'b0;
    p_raddr      = n_r;
    k_we         = 1'b0;
    k_re         = 1'b0;
    k_raddr      = kidx_r;
    res_valid    = 1'b0;
    res          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          data_nxt = in_data.data_in;
          unique case (in_data.func)
            FUNC_LOAD: begin
              k_we = key_ok;
            end
            FUNC_START: begin
              cnt_save_nxt = count_r;
              count_nxt    = '0;
              n_nxt        = '0;
              state_nxt    = ST_INIT;
            end
            FUNC_CRYPT: begin
              count_nxt = count_r + 32'd1;
              i_nxt     = i_r + 8'd1;
              p_re      = 1'b1;
              p_raddr   = i_r + 8'd1;
              state_nxt = ST_E_RJ;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        p_we = 1'b1;
        if (n_r == 8'hFF) begin
          // identity done, fetch first entry and first key byte
          p_re      = 1'b1;
          p_raddr   = '0;
          k_re      = 1'b1;
          k_raddr   = '0;
          acc_nxt   = '0;
          kidx_nxt  = '0;
          hz_nxt    = 1'b0;
          n_nxt     = '0;
          state_nxt = ST_K_ACC;
        end else begin
          n_nxt = n_r + 8'd1;
        end
      end
      ST_K_ACC: begin
        sn_nxt    = fwd;
        acc_nxt   = acc_sum;
        p_re      = 1'b1;
        p_raddr   = acc_sum;
        state_nxt = ST_K_WN;
      end
      ST_K_WN: begin
        p_we      = 1'b1;
        p_waddr   = n_r;
        p_wdata   = p_rdata;
        state_nxt = ST_K_WA;
      end
      ST_K_WA: begin
        p_we    = 1'b1;
        p_waddr = acc_r;
        p_wdata = sn_r;
        if (n_r == 8'hFF) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_DONE;
        end else begin
          // next step's reads overlap this swap write
          n_nxt     = n_r + 8'd1;
          kidx_nxt  = kidx_adv;
          p_re      = 1'b1;
          p_raddr   = n_r + 8'd1;
          k_re      = 1'b1;
          k_raddr   = kidx_adv;
          hz_nxt    = (acc_r == n_r + 8'd1);
          state_nxt = ST_K_ACC;
        end
      end
      ST_E_RJ: begin
        sn_nxt    = p_rdata;
        j_nxt     = j_sum;
        p_re      = 1'b1;
        p_raddr   = j_sum;
        state_nxt = ST_E_WI;
      end
      ST_E_WI: begin
        p_we      = 1'b1;
        p_waddr   = i_r;
        p_wdata   = p_rdata;
        sj_nxt    = p_rdata;
        state_nxt = ST_E_WJ;
      end
      ST_E_WJ: begin
        p_we      = 1'b1;
        p_waddr   = j_r;
        p_wdata   = sn_r;
        p_re      = 1'b1;
        p_raddr   = ks_addr;
        hz_nxt    = (ks_addr == j_r);
        state_nxt = ST_E_KS;
      end
      ST_E_KS: begin
        res_valid     = 1'b1;
        res.data_out  = data_r ^ fwd;
        res.age_count = count_r;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        res_valid     = 1'b1;
        res.data_out  = '0;
        res.age_count = cnt_save_r;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    acc_r      <= acc_nxt;
    kidx_r     <= kidx_nxt;
    sn_r       <= sn_nxt;
    sj_r       <= sj_nxt;
    data_r     <= data_nxt;
    hz_r       <= hz_nxt;
    cnt_save_r <= cnt_save_nxt;
  end

endmodule

FILE: hw/rtl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 engine: key byte load, key scheduling on start, one keystream byte
// per encrypt beat, with a registered result stage and key length register.
// ----------------------------------------------------------------------------
//   channel | dir | handshake             | payload
//   in      | in  | in_valid / in_ready   | in_data (func, key_index, data_in)
//   out     | out | out_valid / out_ready | out_data (data_out, age_count)
//   cfg     | in  | cfg_valid / cfg_ready | cfg_data (key period, 9 bits)
//
// load beat: the key byte is written as it is taken. encrypt beat: dependent
// read, swap and keystream read on the single perm ram read port, then the
// result register. start beat: 256 identity writes, then 256 shuffle steps
// through the K_ACC, K_WN and K_WA states. reset clears indices, count and
// key length (16); ram contents are undefined until written. the next input
// beat is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int KEY_MAX = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rc4_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rc4_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rc4_pkg::KEY_LEN_W-1:0]   cfg_data
);

  import rc4_pkg::*;

  logic [KEY_LEN_W-1:0] key_len_r;
  logic [KEY_LEN_W-1:0] period;
  logic                 out_valid_r;
  out_t                 out_r;
  logic                 res_valid;
  logic                 res_ready;
  out_t                 res;

  assign cfg_ready = 1'b1;

  // key period clamped to 1..KEY_MAX
  always_comb begin
    if (key_len_r == '0) begin
      period = KEY_LEN_W'(1);
    end else if (key_len_r > KEY_LEN_W'(KEY_MAX)) begin
      period = KEY_LEN_W'(KEY_MAX);
    end else begin
      period = key_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= KEY_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      key_len_r <= cfg_data;
    end
  end

  rc4_engine #(.KEY_MAX(KEY_MAX)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .period    (period),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // engine never takes a beat while it still holds a result
  a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  // key load completes in the beat's own cycle
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.func == FUNC_LOAD) |=> in_ready)
    else $error("key load did not return to idle");

  // start and encrypt occupy the engine past their accept cycle
  a_work_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready &&
     (in_data.func == FUNC_START || in_data.func == FUNC_CRYPT)) |=> !in_ready)
    else $error("engine idle right after start or encrypt");

  // a result the sink refused is not overwritten
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result register overwritten while full");

endmodule
